>>> rtl/kci_pkg.sv
// ----------------------------------------------------------------------------
// kci_pkg: shared types and constants of the keyframe curve interpolator
// Holds the item and divider types, the mode codes and the register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package kci_pkg;
  localparam int unsigned CHANNELS      = 3;
  localparam int unsigned KEYS_DEF      = 64;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned TIME_W        = 47;
  localparam int unsigned SAMP_W        = 48;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned IDX_W         = 6;
  localparam int unsigned CH_W          = 2;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned CNT_IN_W      = 7;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned QUO_W         = 24;
  localparam int unsigned STEP_W        = 6;
  localparam int unsigned DIV_W         = 48;

  // mode codes; any other code behaves as hold
  localparam logic [MODE_W-1:0] MODE_CYCLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALONG = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HOLD  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_Z = 3'd6;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic [CH_W-1:0]           channel;
    logic [IDX_W-1:0]          key_index;
    logic [TIME_W-1:0]         key_time;
    logic signed [VAL_W-1:0]   key_value;
    logic signed [SAMP_W-1:0]  sample_time;
  } item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  rem0;
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

>>> rtl/kci_front.sv
// ----------------------------------------------------------------------------
// kci_front: input side of the interpolator
// Accepts items, drops loads that address no key, and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none
module kci_front #(
  parameter int unsigned KEYS = kci_pkg::KEYS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_op,
  input  wire logic [kci_pkg::CH_W-1:0]           in_channel,
  input  wire logic [kci_pkg::IDX_W-1:0]          in_key_index,
  input  wire logic [kci_pkg::TIME_W-1:0]         in_key_time,
  input  wire logic signed [kci_pkg::VAL_W-1:0]   in_key_value,
  input  wire logic signed [kci_pkg::SAMP_W-1:0]  in_sample_time,
  output logic                                    q_valid,
  output kci_pkg::item_t                          q_item,
  input  wire logic                               q_pop
);
  import kci_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       keep;
  logic       push;
  item_t      item;

  // classify: a load outside the channels or keys is dropped
  always_comb begin
    item.op          = op_t'(in_op);
    item.channel     = in_channel;
    item.key_index   = in_key_index;
    item.key_time    = in_key_time;
    item.key_value   = in_key_value;
    item.sample_time = in_sample_time;
    keep = (item.op == OP_SAMPLE) ||
           ((32'(in_channel) < 32'(CHANNELS)) && (32'(in_key_index) < 32'(KEYS)));
  end

  assign in_ready = (fill_r != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (fill_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];

  // two-entry queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wr_ptr_r] <= item;
        wr_ptr_r         <= ~wr_ptr_r;
      end
      if (q_pop && q_valid) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      fill_r <= fill_r + 2'(push) - 2'(q_pop && q_valid);
    end
  end
endmodule
`default_nettype wire

>>> rtl/kci_div.sv
// ----------------------------------------------------------------------------
// kci_div: bit-serial restoring divider
// One quotient bit per cycle; serves both the time wrap and the fraction.
// ----------------------------------------------------------------------------
`default_nettype none
module kci_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire kci_pkg::div_req_t req,
  output kci_pkg::div_rsp_t      rsp
);
  import kci_pkg::*;

  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  num_r;
  logic [DIV_W-1:0]  den_r;
  logic [QUO_W-1:0]  quo_r;
  logic [STEP_W-1:0] steps_r;
  logic              busy_r;
  logic [DIV_W:0]    trial;
  logic              ge;
  logic [DIV_W:0]    diff;

  // shift in one dividend bit and try the subtract
  always_comb begin
    trial = {rem_r, num_r[DIV_W-1]};
    ge    = (trial >= {1'b0, den_r});
    diff  = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      steps_r <= '0;
    end else if (req.start) begin
      rem_r   <= req.rem0;
      num_r   <= req.num;
      den_r   <= req.den;
      quo_r   <= '0;
      steps_r <= req.steps;
      busy_r  <= 1'b1;
    end else if (busy_r) begin
      rem_r   <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      num_r   <= {num_r[DIV_W-2:0], 1'b0};
      quo_r   <= {quo_r[QUO_W-2:0], ge};
      steps_r <= steps_r - 1'b1;
      busy_r  <= (steps_r != STEP_W'(1));
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.rem  = rem_r;
  assign rsp.quo  = quo_r;
endmodule
`default_nettype wire

>>> rtl/kci_back.sv
// ----------------------------------------------------------------------------
// kci_back: execution side of the interpolator
// Writes keys, searches the bracketing keys per channel and blends them.
// ----------------------------------------------------------------------------
`default_nettype none
module kci_back #(
  parameter int unsigned KEYS          = kci_pkg::KEYS_DEF,
  parameter int unsigned FRACTION_BITS = kci_pkg::FRAC_BITS_DEF,
  localparam int unsigned CW           = $clog2(KEYS + 1)
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 q_valid,
  input  wire kci_pkg::item_t                       q_item,
  output logic                                      q_pop,
  input  wire logic [kci_pkg::MODE_W-1:0]           mode,
  input  wire logic [2:0][kci_pkg::VAL_W-1:0]       init,
  input  wire logic [2:0][CW-1:0]                   count,
  output kci_pkg::div_req_t                         div_req,
  input  wire kci_pkg::div_rsp_t                    div_rsp,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [kci_pkg::VAL_W-1:0]          out_value_x,
  output logic signed [kci_pkg::VAL_W-1:0]          out_value_y,
  output logic signed [kci_pkg::VAL_W-1:0]          out_value_z
);
  import kci_pkg::*;

  localparam int unsigned DEPTH = CHANNELS * KEYS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = VAL_W + 2 + FRACTION_BITS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CH, ST_LAST, ST_MOD, ST_LEFT, ST_LEFT_GOT, ST_SCAN, ST_SCAN_GOT,
    ST_FRAC, ST_FRAC_WAIT, ST_MUL, ST_ADD, ST_NEXT, ST_OUT
  } state_t;

  state_t                      state_r;
  logic [TIME_W+VAL_W-1:0]     mem [DEPTH];
  logic [TIME_W+VAL_W-1:0]     rd_q;
  logic [AW-1:0]               rd_addr;
  logic [AW-1:0]               wr_addr;
  logic                        wr_en;
  logic [CH_W-1:0]             ch_r;
  logic signed [SAMP_W-1:0]    tin_r;
  logic signed [SAMP_W-1:0]    t_r;
  logic [CW-1:0]               pos_r;
  logic [CW-1:0]               cur_r [CHANNELS];
  logic [TIME_W-1:0]           left_t_r;
  logic signed [VAL_W-1:0]     left_v_r;
  logic [TIME_W-1:0]           right_t_r;
  logic signed [VAL_W-1:0]     right_v_r;
  logic [FRACTION_BITS-1:0]    frac_r;
  logic signed [PW-1:0]        prod_r;
  logic signed [VAL_W-1:0]     val_r [CHANNELS];
  logic                        out_valid_r;
  logic signed [VAL_W-1:0]     out_x_r;
  logic signed [VAL_W-1:0]     out_y_r;
  logic signed [VAL_W-1:0]     out_z_r;

  logic [AW-1:0]               base;
  logic [CW-1:0]               cnt_cur;
  logic signed [VAL_W-1:0]     init_cur;
  logic [TIME_W-1:0]           rd_t;
  logic signed [VAL_W-1:0]     rd_v;
  logic [TIME_W-1:0]           t_u;
  logic signed [TIME_W+1:0]    diff_tl;
  logic signed [TIME_W+1:0]    span;
  logic                        frac_ok;
  logic                        wrap;
  logic [CW-1:0]               start_pos;
  logic signed [VAL_W:0]       dv;

  // per-channel operands and key fields
  always_comb begin
    base      = AW'(ch_r) * AW'(KEYS);
    cnt_cur   = count[ch_r];
    init_cur  = init[ch_r];
    rd_t      = rd_q[TIME_W+VAL_W-1:VAL_W];
    rd_v      = rd_q[VAL_W-1:0];
    t_u       = t_r[TIME_W-1:0];
    diff_tl   = signed'({2'b0, t_u}) - signed'({2'b0, left_t_r});
    span      = signed'({2'b0, right_t_r}) - signed'({2'b0, left_t_r});
    frac_ok   = (diff_tl > 0) && (span > 0) && (t_u < right_t_r);
    wrap      = (mode == MODE_CYCLE) && (rd_t != '0) && (t_u >= rd_t);
    start_pos = (mode == MODE_ALONG) ? cur_r[ch_r] : '0;
    dv        = signed'({right_v_r[VAL_W-1], right_v_r}) -
                signed'({left_v_r[VAL_W-1], left_v_r});
    wr_addr   = AW'(q_item.channel) * AW'(KEYS) + AW'(q_item.key_index);
  end

  // memory address, queue pop and divider requests
  always_comb begin
    q_pop   = 1'b0;
    wr_en   = 1'b0;
    rd_addr = base + AW'(pos_r);
    div_req = '0;
    case (state_r)
      ST_IDLE: begin
        q_pop = q_valid;
        wr_en = q_valid && (q_item.op == OP_LOAD);
      end
      ST_CH: begin
        rd_addr = base + AW'(cnt_cur) - AW'(1);
      end
      ST_LEFT: begin
        rd_addr = base + AW'(pos_r) - AW'(1);
      end
      ST_LAST: begin
        div_req.start = wrap;
        div_req.num   = t_r[DIV_W-1:0];
        div_req.den   = {1'b0, rd_t};
        div_req.steps = STEP_W'(DIV_W);
      end
      ST_FRAC: begin
        div_req.start = frac_ok;
        div_req.rem0  = diff_tl[DIV_W-1:0];
        div_req.den   = span[DIV_W-1:0];
        div_req.steps = STEP_W'(FRACTION_BITS);
      end
      default: begin
      end
    endcase
  end

  // key memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {q_item.key_time, q_item.key_value};
    end
    rd_q <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ch_r        <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        cur_r[i] <= '0;
      end
    end else begin
      // drop a taken result unless a new one replaces it
      if (out_valid_r && out_ready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_item.op == OP_LOAD) begin
              cur_r[q_item.channel] <= '0;
            end else begin
              tin_r   <= q_item.sample_time;
              ch_r    <= '0;
              state_r <= ST_CH;
            end
          end
        end
        ST_CH: begin
          t_r <= tin_r;
          if (tin_r < 0 || cnt_cur == '0) begin
            val_r[ch_r] <= init_cur;
            state_r     <= ST_NEXT;
          end else begin
            state_r <= ST_LAST;
          end
        end
        ST_LAST: begin
          if (mode == MODE_CYCLE) begin
            if (rd_t == '0) begin
              val_r[ch_r] <= rd_v;
              state_r     <= ST_NEXT;
            end else if (wrap) begin
              state_r <= ST_MOD;
            end else begin
              pos_r   <= '0;
              state_r <= ST_LEFT;
            end
          end else if (t_u >= rd_t || start_pos >= cnt_cur) begin
            val_r[ch_r] <= rd_v;
            state_r     <= ST_NEXT;
          end else begin
            pos_r   <= start_pos;
            state_r <= ST_LEFT;
          end
        end
        ST_MOD: begin
          if (!div_rsp.busy) begin
            t_r     <= signed'({1'b0, div_rsp.rem[TIME_W-1:0]});
            pos_r   <= '0;
            state_r <= ST_LEFT;
          end
        end
        ST_LEFT: begin
          if (pos_r == '0) begin
            left_t_r <= '0;
            left_v_r <= init_cur;
            state_r  <= ST_SCAN;
          end else begin
            state_r <= ST_LEFT_GOT;
          end
        end
        ST_LEFT_GOT: begin
          left_t_r <= rd_t;
          left_v_r <= rd_v;
          state_r  <= ST_SCAN;
        end
        ST_SCAN: begin
          state_r <= ST_SCAN_GOT;
        end
        ST_SCAN_GOT: begin
          // advance while the key lies at or before the time
          if (pos_r < cnt_cur && rd_t <= t_u) begin
            left_t_r <= rd_t;
            left_v_r <= rd_v;
            pos_r    <= pos_r + 1'b1;
            state_r  <= ST_SCAN;
          end else begin
            right_t_r <= rd_t;
            right_v_r <= rd_v;
            if (mode == MODE_ALONG) begin
              cur_r[ch_r] <= pos_r;
            end
            state_r <= ST_FRAC;
          end
        end
        ST_FRAC: begin
          frac_r  <= '0;
          state_r <= frac_ok ? ST_FRAC_WAIT : ST_MUL;
        end
        ST_FRAC_WAIT: begin
          if (!div_rsp.busy) begin
            frac_r  <= div_rsp.quo[FRACTION_BITS-1:0];
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= PW'(dv * signed'({1'b0, frac_r}));
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          // arithmetic shift floors the scaled difference
          val_r[ch_r] <= left_v_r + prod_r[FRACTION_BITS+VAL_W-1:FRACTION_BITS];
          state_r     <= ST_NEXT;
        end
        ST_NEXT: begin
          if (ch_r == CH_W'(CHANNELS - 1)) begin
            state_r <= ST_OUT;
          end else begin
            ch_r    <= ch_r + 1'b1;
            state_r <= ST_CH;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_x_r     <= val_r[0];
            out_y_r     <= val_r[1];
            out_z_r     <= val_r[2];
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_value_x = out_x_r;
  assign out_value_y = out_y_r;
  assign out_value_z = out_z_r;
endmodule
`default_nettype wire

>>> rtl/keyframe_curve_interpolator_unit.sv
// ----------------------------------------------------------------------------
// keyframe_curve_interpolator_unit: piecewise linear keyframe sampler
// Three channels of ascending keys, sampled together at one time.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*: register writes (mode, initial values, key counts), one per cycle,
//          only while the block is idle. Unknown indexes are ignored.
//   in_*:  a load item (op 0) stores one key and gives no result; a sample
//          item (op 1) gives one result on out_* with the x, y, z values.
//   A two-entry queue sits in front of the sequencer, so items are taken
//   while the sequencer works or while a result waits in the output register.
// Sequencing:
//   A load is written in the idle state; a sample is popped, then each
//   channel takes the initial value or the last key value, or else divides
//   the time when cycle mode wraps it, scans the keys passed (from the along
//   cursor when set), divides the fraction when needed, multiplies and adds.
//   The result is registered into out_* once the third channel is done.
// Reset: mode is hold, counts, initial values and cursors are zero. Key
//   storage is not cleared. A stalled out_ready holds the result and the
//   sequencer, and the queue fills and then drops in_ready.
// ----------------------------------------------------------------------------
`default_nettype none
module keyframe_curve_interpolator_unit #(
  parameter int unsigned KEYS          = kci_pkg::KEYS_DEF,
  parameter int unsigned FRACTION_BITS = kci_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [kci_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [kci_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_op,
  input  wire logic [kci_pkg::CH_W-1:0]            in_channel,
  input  wire logic [kci_pkg::IDX_W-1:0]           in_key_index,
  input  wire logic [kci_pkg::TIME_W-1:0]          in_key_time,
  input  wire logic signed [kci_pkg::VAL_W-1:0]    in_key_value,
  input  wire logic signed [kci_pkg::SAMP_W-1:0]   in_sample_time,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [kci_pkg::VAL_W-1:0]         out_value_x,
  output logic signed [kci_pkg::VAL_W-1:0]         out_value_y,
  output logic signed [kci_pkg::VAL_W-1:0]         out_value_z
);
  import kci_pkg::*;

  localparam int unsigned CW = $clog2(KEYS + 1);

  logic [MODE_W-1:0]       mode_r;
  logic [2:0][VAL_W-1:0]   init_r;
  logic [2:0][CW-1:0]      count_r;
  logic [CW-1:0]           count_sat;
  logic                    cfg_wr;
  logic                    q_valid;
  item_t                   q_item;
  logic                    q_pop;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign count_sat = (32'(cfg_data[CNT_IN_W-1:0]) > 32'(KEYS)) ?
                     CW'(KEYS) : CW'(cfg_data[CNT_IN_W-1:0]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_HOLD;
      init_r  <= '0;
      count_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_MODE:    mode_r     <= cfg_data[MODE_W-1:0];
        REG_INIT_X:  init_r[0]  <= cfg_data;
        REG_INIT_Y:  init_r[1]  <= cfg_data;
        REG_INIT_Z:  init_r[2]  <= cfg_data;
        REG_COUNT_X: count_r[0] <= count_sat;
        REG_COUNT_Y: count_r[1] <= count_sat;
        REG_COUNT_Z: count_r[2] <= count_sat;
        default: begin
        end
      endcase
    end
  end

  kci_front #(
    .KEYS (KEYS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_channel     (in_channel),
    .in_key_index   (in_key_index),
    .in_key_time    (in_key_time),
    .in_key_value   (in_key_value),
    .in_sample_time (in_sample_time),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  kci_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  kci_back #(
    .KEYS          (KEYS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .mode        (mode_r),
    .init        (init_r),
    .count       (count_r),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_value_x (out_value_x),
    .out_value_y (out_value_y),
    .out_value_z (out_value_z)
  );

  // the divider is never restarted while it runs
  a_div_no_restart : assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // the sequencer pops only a queued item
  a_pop_valid : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // no result is shown right after reset
  a_reset_out : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the keyframe curve interpolator
// Loads keys, samples the three channels in every mode and compares each
// result with a local predictor, with random idling on both sides in some phases.
// ----------------------------------------------------------------------------
module tb_top;
  import kci_pkg::*;

  localparam int NKEY = 64;
  localparam int FB   = 16;

  // predictor state
  logic [TIME_W-1:0]       pr_time [CHANNELS][NKEY];
  logic signed [VAL_W-1:0] pr_val  [CHANNELS][NKEY];
  int unsigned             pr_cur  [CHANNELS];
  logic [MODE_W-1:0]       pr_mode;
  logic signed [VAL_W-1:0] pr_init [CHANNELS];
  int unsigned             pr_cnt  [CHANNELS];
  // how many keys have been written per channel, counted from slot 0 up
  int                      written [CHANNELS];

  function automatic longint unsigned blend_frac(longint unsigned num,
                                                 longint unsigned den);
    longint unsigned rem, q;
    rem = num;
    q = 0;
    for (int i = 0; i < FB; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [VAL_W-1:0] curve_value(int ch, longint t_in);
    longint t, last, lt, rt, lv, rv, d, p, q, lastv;
    int unsigned n, pos;
    longint unsigned fr;
    t = t_in;
    n = pr_cnt[ch];
    fr = 0;
    if (t < 0 || n == 0) return pr_init[ch];
    last = longint'(pr_time[ch][n-1]);
    lastv = longint'(pr_val[ch][n-1]);
    if (pr_mode == MODE_CYCLE) begin
      if (last == 0) return lastv;
      if (t >= last) t = t % last;
      pos = 0;
    end else begin
      if (t >= last) return lastv;
      pos = (pr_mode == MODE_ALONG) ? pr_cur[ch] : 0;
      if (pos >= n) return lastv;
    end
    while (pos < n && longint'(pr_time[ch][pos]) <= t) pos++;
    if (pr_mode == MODE_ALONG) pr_cur[ch] = pos;
    lt = (pos == 0) ? 0 : longint'(pr_time[ch][pos-1]);
    lv = (pos == 0) ? longint'(pr_init[ch]) : longint'(pr_val[ch][pos-1]);
    rt = longint'(pr_time[ch][pos]);
    rv = longint'(pr_val[ch][pos]);
    if (t - lt > 0 && rt - lt > 0 && t < rt) fr = blend_frac(t - lt, rt - lt);
    d = rv - lv;
    p = d * longint'(fr);
    if (p >= 0) q = p >>> FB;
    else q = -longint'((unsigned'(-p) + ((64'd1 << FB) - 1)) >> FB);
    return VAL_W'(lv + q);
  endfunction

  typedef struct {
    logic signed [VAL_W-1:0] x, y, z;
  } sample_t;

  // scoreboard: holds expected samples in order
  class sample_board;
    sample_t pending[$];
    int errors;

    function void note_item(item_t it);
      sample_t s;
      if (it.op == OP_LOAD) begin
        if (it.channel < CHANNELS && it.key_index < NKEY) begin
          pr_time[it.channel][it.key_index] = it.key_time;
          pr_val[it.channel][it.key_index]  = it.key_value;
          pr_cur[it.channel] = 0;
        end
        return;
      end
      s.x = curve_value(0, longint'(it.sample_time));
      s.y = curve_value(1, longint'(it.sample_time));
      s.z = curve_value(2, longint'(it.sample_time));
      pending = {pending, s};
    endfunction

    function void check_result(logic signed [VAL_W-1:0] x, y, z);
      sample_t s;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %0d %0d %0d", x, y, z);
        errors++;
        return;
      end
      s = pending.pop_front();
      if (x !== s.x) begin
        $error("value_x expected %0d got %0d", s.x, x); errors++;
      end
      if (y !== s.y) begin
        $error("value_y expected %0d got %0d", s.y, y); errors++;
      end
      if (z !== s.z) begin
        $error("value_z expected %0d got %0d", s.z, z); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready, in_op;
  logic [CH_W-1:0] in_channel;
  logic [IDX_W-1:0] in_key_index;
  logic [TIME_W-1:0] in_key_time;
  logic signed [VAL_W-1:0] in_key_value;
  logic signed [SAMP_W-1:0] in_sample_time;
  logic out_valid, out_ready;
  logic signed [VAL_W-1:0] out_value_x, out_value_y, out_value_z;

  int send_idle, recv_idle;
  sample_board board;

  keyframe_curve_interpolator_unit dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stall, check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_value_x, out_value_y, out_value_z);
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // cfg_valid is dropped by the next item or drain
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:    pr_mode = data[MODE_W-1:0];
      REG_INIT_X:  pr_init[0] = data;
      REG_INIT_Y:  pr_init[1] = data;
      REG_INIT_Z:  pr_init[2] = data;
      REG_COUNT_X: pr_cnt[0] = (data[6:0] > NKEY) ? NKEY : data[6:0];
      REG_COUNT_Y: pr_cnt[1] = (data[6:0] > NKEY) ? NKEY : data[6:0];
      REG_COUNT_Z: pr_cnt[2] = (data[6:0] > NKEY) ? NKEY : data[6:0];
      default: ;
    endcase
  endtask

  // in_valid stays high into the next item unless the sender idles
  task automatic send_item(item_t it);
    cfg_valid <= 0;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1; in_op <= it.op; in_channel <= it.channel;
    in_key_index <= it.key_index; in_key_time <= it.key_time;
    in_key_value <= it.key_value; in_sample_time <= it.sample_time;
    do @(posedge clk); while (!in_ready);
    board.note_item(it);
  endtask

  // wait for all results, then let the sequencer drain
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 0;
    cfg_valid <= 0;
    while (board.pending.size() != 0 && guard < 400000) begin
      @(posedge clk); guard++;
    end
    repeat (400) @(posedge clk);
  endtask

  task automatic load_key(int ch, int idx, logic [TIME_W-1:0] t, logic [VAL_W-1:0] v);
    item_t it;
    it = '0;
    it.op = OP_LOAD; it.channel = CH_W'(ch); it.key_index = IDX_W'(idx);
    it.key_time = t; it.key_value = v;
    it.sample_time = SAMP_W'({$urandom, $urandom});
    send_item(it);
    if (ch < CHANNELS && idx == written[ch]) written[ch]++;
  endtask

  task automatic sample_at(logic signed [SAMP_W-1:0] t);
    item_t it;
    it = '0;
    it.op = OP_SAMPLE; it.sample_time = t;
    it.channel = CH_W'($urandom); it.key_index = IDX_W'($urandom);
    it.key_time = TIME_W'({$urandom, $urandom}); it.key_value = $urandom;
    send_item(it);
  endtask

  // keys in order of time with random steps, repeats when dup is set; few keys mostly, sometimes all 64
  task automatic build_channel(int ch, int n, int step_max, bit dup);
    logic [TIME_W-1:0] t;
    t = (dup && $urandom_range(1)) ? 0 : $urandom_range(1, step_max);
    for (int k = 0; k < n; k++) begin
      load_key(ch, k, t, $urandom);
      if (!(dup && $urandom_range(4) == 0)) t = t + $urandom_range(1, step_max);
    end
  endtask

  task automatic set_counts(int cx, int cy, int cz);
    for (int c = 0; c < CHANNELS; c++)
      if ((c == 0 ? cx : c == 1 ? cy : cz) > written[c])
        $error("count beyond loaded keys");
    write_reg(REG_COUNT_X, cx);
    write_reg(REG_COUNT_Y, cy);
    write_reg(REG_COUNT_Z, cz);
  endtask

  function automatic logic signed [SAMP_W-1:0] pick_time();
    longint last;
    last = longint'(pr_time[0][(written[0] > 0) ? written[0]-1 : 0]);
    case ($urandom_range(5))
      0: return -SAMP_W'($urandom_range(1, 1000));
      1: return {1'b1, TIME_W'({$urandom, $urandom})};
      2: return {1'b0, TIME_W'({$urandom, $urandom})};
      3: return SAMP_W'(last + longint'($urandom_range(0, 3)));
      default: return SAMP_W'($urandom_range(0, int'(last) + 5));
    endcase
  endfunction

  task automatic phase(int items, int mode_code);
    drain();
    write_reg(REG_MODE, mode_code);
    write_reg(REG_INIT_X, $urandom);
    write_reg(REG_INIT_Y, $urandom);
    write_reg(REG_INIT_Z, $urandom);
    set_counts($urandom_range(0, written[0]), $urandom_range(0, written[1]),
               $urandom_range(0, written[2]));
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(9) == 0)
        load_key($urandom_range(3), $urandom_range(63), TIME_W'({$urandom, $urandom}),
                 $urandom);
      else sample_at(pick_time());
    end
  endtask

  initial begin
    board = new();
    rst_n = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; in_op = 0; in_channel = '0; in_key_index = '0;
    in_key_time = '0; in_key_value = '0; in_sample_time = '0; out_ready = 0;
    pr_mode = MODE_HOLD;
    for (int c = 0; c < CHANNELS; c++) begin
      pr_cur[c] = 0; pr_init[c] = 0; pr_cnt[c] = 0; written[c] = 0;
      for (int k = 0; k < NKEY; k++) begin
        pr_time[c][k] = '0; pr_val[c][k] = '0;
      end
    end
    send_idle = 0; recv_idle = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: zero counts, extremes of time and value, ignored loads
    sample_at({1'b0, {47{1'b1}}});
    sample_at({1'b1, 47'd0});
    load_key(0, 0, 47'd100, 32'h7FFF_FFFF);
    load_key(0, 1, {47{1'b1}}, 32'h8000_0000);
    load_key(1, 0, 47'd0, 32'h0001_0000);
    load_key(1, 1, 47'd0, 32'hFFFF_0000);
    load_key(2, 0, 47'd10, 32'h0);
    load_key(3, 5, 47'd5, 32'h1234);
    load_key(2, 63, 47'd1, 32'h1);
    written[2] = 1;
    drain();
    write_reg(REG_INIT_X, 32'h8000_0000);
    write_reg(REG_INIT_Y, 32'h7FFF_FFFF);
    write_reg(REG_INIT_Z, 32'h0);
    write_reg(3'd7, 32'hFFFF_FFFF);
    write_reg(REG_COUNT_X, 2); write_reg(REG_COUNT_Y, 2); write_reg(REG_COUNT_Z, 1);
    sample_at(48'd0); sample_at(48'd50); sample_at(48'd100);
    sample_at(48'd1000); sample_at({1'b0, {47{1'b1}}}); sample_at(-48'sd1);
    drain();
    write_reg(REG_MODE, MODE_CYCLE);
    sample_at(48'd150); sample_at({1'b0, {47{1'b1}}}); sample_at(48'd3);
    drain();
    write_reg(REG_MODE, MODE_ALONG);
    sample_at(48'd120); sample_at(48'd30); sample_at({1'b0, {47{1'b1}}});
    drain();
    write_reg(REG_MODE, 2'd3);
    sample_at(48'd5);

    // rebuild channels with sane keys, then random phases
    drain();
    build_channel(0, 64, 50, 0);
    build_channel(1, 8, 1000, 1);
    build_channel(2, 5, 3, 0);
    drain();
    write_reg(REG_COUNT_X, 127);
    sample_at(48'd20);

    send_idle = 38; recv_idle = 46;
    phase(50, MODE_CYCLE);
    phase(50, MODE_ALONG);
    send_idle = 46; recv_idle = 38;
    phase(50, MODE_HOLD);
    phase(50, 2'd3);
    // hold off until every expected result is back
    drain();
    send_idle = 0; recv_idle = 0;
    build_channel(0, 6, 20, 0);
    phase(60, MODE_ALONG);
    phase(60, MODE_CYCLE);
    drain();

    if (board.errors == 0 && board.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

>>> filelist.f
rtl/kci_pkg.sv
rtl/kci_front.sv
rtl/kci_div.sv
rtl/kci_back.sv
rtl/keyframe_curve_interpolator_unit.sv
tb/tb_top.sv
